/* src/dpt_pkg.sv */
// Package: payload types, state type, register indexes and indicator color codes.
`default_nettype none
package dpt_pkg;

  localparam int unsigned RegCount = 5;
  localparam int unsigned AddrWidth = 5;

  localparam logic [2:0] REG_RELEASE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_PRESS_THRESHOLD   = 3'd1;
  localparam logic [2:0] REG_INTEGRATOR_LIMIT  = 3'd2;
  localparam logic [2:0] REG_LOCKOUT_MS        = 3'd3;
  localparam logic [2:0] REG_FLASH_MS          = 3'd4;

  localparam logic [1:0] COL_GREEN = 2'd0;
  localparam logic [1:0] COL_RED   = 2'd1;
  localparam logic [1:0] COL_BLUE  = 2'd2;
  localparam logic [1:0] COL_CYAN  = 2'd3;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic button_pressed;
    logic enable_level;
    logic message_seen;
    logic ms_tick;
  } in_item_t;

  typedef struct packed {
    logic       paused;
    logic       relay_on;
    logic       thru_on;
    logic [1:0] indicator_colour;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  release_threshold;
    logic [7:0]  press_threshold;
    logic [7:0]  integrator_limit;
    logic [15:0] lockout_ms;
    logic [15:0] flash_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  press_integrator;
    logic        debounced_pressed;
    logic        pause_flag;
    logic [15:0] since_release_ms;
    logic [15:0] since_message_ms;
    logic        flash_active;
    logic [1:0]  colour_now;
  } state_t;

endpackage
`default_nettype wire

/* src/dpt_step.sv */
// Next-state and result logic for one poll pass.
`default_nettype none
module dpt_step (
  input  wire dpt_pkg::cfg_t     cfg,
  input  wire dpt_pkg::state_t   st,
  input  wire dpt_pkg::in_item_t item,
  output dpt_pkg::state_t        st_next,
  output dpt_pkg::out_item_t     result
);

  logic [15:0] rel_ms;
  logic [15:0] msg_ms;
  logic [7:0]  integ;

  always_comb begin
    rel_ms = st.since_release_ms;
    msg_ms = st.since_message_ms;
    if (item.ms_tick) begin
      if (rel_ms != dpt_pkg::TIMER_MAX) rel_ms = rel_ms + 16'd1;
      if (msg_ms != dpt_pkg::TIMER_MAX) msg_ms = msg_ms + 16'd1;
    end

    integ = st.press_integrator;
    if (item.button_pressed) begin
      if (integ < cfg.integrator_limit) integ = integ + 8'd1;
    end else if (integ != 8'd0) begin
      integ = integ - 8'd1;
    end

    st_next = st;
    st_next.press_integrator = integ;
    st_next.since_release_ms = rel_ms;
    st_next.since_message_ms = msg_ms;

    if (item.enable_level) begin
      if (integ < cfg.release_threshold && st.debounced_pressed) begin
        st_next.since_release_ms  = 16'd0;
        st_next.debounced_pressed = 1'b0;
      end else if (integ > cfg.press_threshold && !st.debounced_pressed &&
                   rel_ms > cfg.lockout_ms) begin
        st_next.debounced_pressed = 1'b1;
        st_next.pause_flag        = !st.pause_flag;
        st_next.colour_now        = st.pause_flag ? dpt_pkg::COL_GREEN : dpt_pkg::COL_RED;
      end
    end

    if (item.message_seen) begin
      st_next.since_message_ms = 16'd0;
      st_next.colour_now       = dpt_pkg::COL_BLUE;
      st_next.flash_active     = 1'b1;
    end

    // flash expiry reverts to the pause color, or cyan when disabled
    if (st_next.flash_active && st_next.since_message_ms > cfg.flash_ms) begin
      if (item.enable_level) begin
        st_next.colour_now = st_next.pause_flag ? dpt_pkg::COL_RED : dpt_pkg::COL_GREEN;
      end else begin
        st_next.colour_now = dpt_pkg::COL_CYAN;
      end
      st_next.flash_active = 1'b0;
    end

    result.paused           = st_next.pause_flag;
    result.relay_on         = st_next.pause_flag;
    result.thru_on          = !st_next.pause_flag;
    result.indicator_colour = st_next.colour_now;
  end

endmodule
`default_nettype wire

/* src/debounced_pause_toggle_indicator_core.sv */
// Top level: config registers, pass state, output register and handshakes.
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while in_ready is high; state updates in a single registered pass.
// in_ready stays high while the output register is empty or being drained.
// Reset (synchronous, active high) clears state, restores register defaults
// and empties the output register.
`default_nettype none
module debounced_pause_toggle_indicator_core (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire dpt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output dpt_pkg::out_item_t      out_data,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire [dpt_pkg::AddrWidth-1:0] paddr,
  input  wire [31:0]              pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  dpt_pkg::cfg_t      cfg;
  dpt_pkg::state_t    st;
  dpt_pkg::state_t    st_next;
  dpt_pkg::out_item_t result;
  logic               accept;
  logic               cfg_write;
  logic [2:0]         reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[dpt_pkg::AddrWidth-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.release_threshold <= 8'd20;
      cfg.press_threshold   <= 8'd50;
      cfg.integrator_limit  <= 8'd70;
      cfg.lockout_ms        <= 16'd300;
      cfg.flash_ms          <= 16'd1000;
    end else if (cfg_write) begin
      unique case (reg_index)
        dpt_pkg::REG_RELEASE_THRESHOLD: cfg.release_threshold <= pwdata[7:0];
        dpt_pkg::REG_PRESS_THRESHOLD:   cfg.press_threshold   <= pwdata[7:0];
        dpt_pkg::REG_INTEGRATOR_LIMIT:  cfg.integrator_limit  <= pwdata[7:0];
        dpt_pkg::REG_LOCKOUT_MS:        cfg.lockout_ms        <= pwdata[15:0];
        dpt_pkg::REG_FLASH_MS:          cfg.flash_ms          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      dpt_pkg::REG_RELEASE_THRESHOLD: prdata = {24'd0, cfg.release_threshold};
      dpt_pkg::REG_PRESS_THRESHOLD:   prdata = {24'd0, cfg.press_threshold};
      dpt_pkg::REG_INTEGRATOR_LIMIT:  prdata = {24'd0, cfg.integrator_limit};
      dpt_pkg::REG_LOCKOUT_MS:        prdata = {16'd0, cfg.lockout_ms};
      dpt_pkg::REG_FLASH_MS:          prdata = {16'd0, cfg.flash_ms};
      default:                        prdata = 32'd0;
    endcase
  end

  dpt_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_data),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_message_shows_blue: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.message_seen |=> out_data.indicator_colour == dpt_pkg::COL_BLUE)
    else $error("message did not force blue");

  a_pause_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(st.pause_flag))
    else $error("pause changed without a transaction");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_data.paused == st.pause_flag &&
               out_data.indicator_colour == st.colour_now)
    else $error("result does not match updated state");
`endif

endmodule
`default_nettype wire

/* bench/debounced_pause_toggle_indicator_core_tb.sv */
// Self-checking bench for the debounced pause toggle core: stream traffic, APB config, scoreboard.
module debounced_pause_toggle_indicator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  dpt_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  dpt_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dpt_pkg::AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // bench copy of the block's registers and pass state
  dpt_pkg::cfg_t regs = '{release_threshold: 8'd20, press_threshold: 8'd50,
                          integrator_limit: 8'd70, lockout_ms: 16'd300, flash_ms: 16'd1000};
  dpt_pkg::state_t ind = '0;

  dpt_pkg::out_item_t pending_indicators[$];
  int mismatches = 0;
  int stall_cycles = 0;
  bit src_gaps = 1'b0;
  bit sink_gaps = 1'b0;
  bit sink_hold = 1'b0;

  debounced_pause_toggle_indicator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic dpt_pkg::out_item_t predict_indicator(dpt_pkg::in_item_t pass);
    dpt_pkg::out_item_t res;
    if (pass.ms_tick) begin
      if (ind.since_release_ms != dpt_pkg::TIMER_MAX)
        ind.since_release_ms = ind.since_release_ms + 16'd1;
      if (ind.since_message_ms != dpt_pkg::TIMER_MAX)
        ind.since_message_ms = ind.since_message_ms + 16'd1;
    end
    if (pass.button_pressed) begin
      if (ind.press_integrator < regs.integrator_limit)
        ind.press_integrator = ind.press_integrator + 8'd1;
    end else if (ind.press_integrator != 8'd0) begin
      ind.press_integrator = ind.press_integrator - 8'd1;
    end
    if (pass.enable_level) begin
      if (ind.press_integrator < regs.release_threshold && ind.debounced_pressed) begin
        ind.since_release_ms = '0;
        ind.debounced_pressed = 1'b0;
      end else if (ind.press_integrator > regs.press_threshold && !ind.debounced_pressed &&
                   ind.since_release_ms > regs.lockout_ms) begin
        ind.debounced_pressed = 1'b1;
        ind.pause_flag = !ind.pause_flag;
        ind.colour_now = ind.pause_flag ? dpt_pkg::COL_RED : dpt_pkg::COL_GREEN;
      end
    end
    if (pass.message_seen) begin
      ind.since_message_ms = '0;
      ind.colour_now = dpt_pkg::COL_BLUE;
      ind.flash_active = 1'b1;
    end
    if (ind.flash_active && ind.since_message_ms > regs.flash_ms) begin
      if (pass.enable_level) ind.colour_now = ind.pause_flag ? dpt_pkg::COL_RED : dpt_pkg::COL_GREEN;
      else ind.colour_now = dpt_pkg::COL_CYAN;
      ind.flash_active = 1'b0;
    end
    res.paused = ind.pause_flag;
    res.relay_on = ind.pause_flag;
    res.thru_on = !ind.pause_flag;
    res.indicator_colour = ind.colour_now;
    return res;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      dpt_pkg::REG_RELEASE_THRESHOLD: return 32'(regs.release_threshold);
      dpt_pkg::REG_PRESS_THRESHOLD:   return 32'(regs.press_threshold);
      dpt_pkg::REG_INTEGRATOR_LIMIT:  return 32'(regs.integrator_limit);
      dpt_pkg::REG_LOCKOUT_MS:        return 32'(regs.lockout_ms);
      default:                        return 32'(regs.flash_ms);
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // prediction on input transactions, comparison on output transactions
  always @(posedge clk) begin
    dpt_pkg::out_item_t want;
    if (!rst && in_valid && in_ready) pending_indicators.push_back(predict_indicator(in_data));
    if (!rst && out_valid && out_ready) begin
      if (pending_indicators.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result %p", $time, out_data);
      end else begin
        want = pending_indicators.pop_front();
        check_field("paused", want.paused, out_data.paused);
        check_field("relay_on", want.relay_on, out_data.relay_on);
        check_field("thru_on", want.thru_on, out_data.thru_on);
        check_field("indicator_colour", want.indicator_colour, out_data.indicator_colour);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result sink: random gaps, or one long hold-off on request
  initial begin : sink
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else begin
        gap = sink_gaps ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_item(dpt_pkg::in_item_t item);
    int gap;
    gap = src_gaps ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_burst(dpt_pkg::in_item_t item, int count);
    repeat (count) send_item(item);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_indicators.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      dpt_pkg::REG_RELEASE_THRESHOLD: regs.release_threshold = data[7:0];
      dpt_pkg::REG_PRESS_THRESHOLD:   regs.press_threshold = data[7:0];
      dpt_pkg::REG_INTEGRATOR_LIMIT:  regs.integrator_limit = data[7:0];
      dpt_pkg::REG_LOCKOUT_MS:        regs.lockout_ms = data[15:0];
      dpt_pkg::REG_FLASH_MS:          regs.flash_ms = data[15:0];
      default: ;
    endcase
  endtask

  task automatic check_registers();
    logic [2:0] idx;
    for (int i = 0; i < dpt_pkg::RegCount; i++) begin
      idx = 3'(i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      check_field($sformatf("register %0d", i), reg_value(idx), prdata);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // upper bits of each write are junk; the register keeps only its own width
  task automatic set_config(int rel, int prs, int lim, int lockout, int flash);
    wait_idle();
    write_reg(dpt_pkg::REG_RELEASE_THRESHOLD, ($urandom() << 8) | rel);
    write_reg(dpt_pkg::REG_PRESS_THRESHOLD, ($urandom() << 8) | prs);
    write_reg(dpt_pkg::REG_INTEGRATOR_LIMIT, ($urandom() << 8) | lim);
    write_reg(dpt_pkg::REG_LOCKOUT_MS, ($urandom() << 16) | lockout);
    write_reg(dpt_pkg::REG_FLASH_MS, ($urandom() << 16) | flash);
    check_registers();
  endtask

  task automatic test_register_access();
    check_registers();
    write_reg(REG_SPARE, $urandom());
    check_registers();
  endtask

  // bit order of each literal: {pressed, enable, message, tick}
  task automatic test_directed_passes();
    set_config(1, 2, 3, 0, 1);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    send_item(dpt_pkg::in_item_t'(4'b0000));
    send_item(dpt_pkg::in_item_t'(4'b1101));
    send_item(dpt_pkg::in_item_t'(4'b1100));
    send_item(dpt_pkg::in_item_t'(4'b1100));  // press after lockout: pause, red
    send_item(dpt_pkg::in_item_t'(4'b1100));  // integrator saturates
    send_item(dpt_pkg::in_item_t'(4'b1110));  // blue flash
    send_item(dpt_pkg::in_item_t'(4'b0101));
    send_item(dpt_pkg::in_item_t'(4'b0101));  // flash expires back to red
    send_item(dpt_pkg::in_item_t'(4'b0100));  // release restarts lockout
    send_burst(dpt_pkg::in_item_t'(4'b1100), 3);  // press inside lockout, no toggle
    send_item(dpt_pkg::in_item_t'(4'b1101));  // same press re-evaluated once lockout passes
    send_item(dpt_pkg::in_item_t'(4'b0010));  // flash while disabled
    send_item(dpt_pkg::in_item_t'(4'b0001));
    send_item(dpt_pkg::in_item_t'(4'b0001));  // expires to cyan
    send_item(dpt_pkg::in_item_t'(4'b0000));
    send_item(dpt_pkg::in_item_t'(4'b0110));
    send_item(dpt_pkg::in_item_t'(4'b1101));
    send_burst(dpt_pkg::in_item_t'(4'b1100), 2);  // toggle during flash
    send_item(dpt_pkg::in_item_t'(4'b0101));
  endtask

  task automatic test_limit_shrink();
    set_config(3, 5, 10, 0, 0);
    send_burst(dpt_pkg::in_item_t'(4'b1101), 10);
    set_config(3, 5, 4, 0, 0);
    send_burst(dpt_pkg::in_item_t'(4'b1101), 3);
    send_burst(dpt_pkg::in_item_t'(4'b0101), 3);
    set_config(3, 5, 0, 0, 0);
    send_burst(dpt_pkg::in_item_t'(4'b1101), 2);
    send_burst(dpt_pkg::in_item_t'(4'b0101), 10);
    send_burst(dpt_pkg::in_item_t'(4'b1101), 3);
  endtask

  // top lockout and flash settings: presses never toggle, the flash never expires
  task automatic test_timer_saturation();
    dpt_pkg::in_item_t item;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    set_config(255, 255, 255, 65535, 65535);
    send_item(dpt_pkg::in_item_t'(4'b0110));
    item = dpt_pkg::in_item_t'(4'b0101);
    for (int i = 0; i < 40; i++) begin
      item.button_pressed = 1'($urandom_range(0, 1));
      send_item(item);
    end
    set_config(255, 255, 255, 65535, 65534);
    send_item(dpt_pkg::in_item_t'(4'b0101));
    set_config(255, 0, 255, 65535, 65534);
    send_burst(dpt_pkg::in_item_t'(4'b1101), 5);
    set_config(255, 0, 255, 65534, 65534);
    send_item(dpt_pkg::in_item_t'(4'b1101));
  endtask

  task automatic test_output_stall();
    dpt_pkg::in_item_t item;
    set_config(2, 6, 8, 3, 5);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = 1'b1;
    for (int i = 0; i < 40; i++) begin
      item = dpt_pkg::in_item_t'(4'($urandom_range(0, 15)));
      item.enable_level = 1'b1;
      send_item(item);
    end
  endtask

  task automatic test_random_traffic();
    dpt_pkg::in_item_t item;
    int lim, rel, prs, sent, len;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(0, 255, 255, 0, 0);
        1: set_config(255, 0, 1, 65535, 65535);
        2: set_config(255, 0, 255, 0, 0);
        default: begin
          lim = $urandom_range(1, 40);
          rel = $urandom_range(0, lim);
          prs = $urandom_range(rel, lim);
          set_config(rel, prs, lim, $urandom_range(0, 40), $urandom_range(0, 40));
        end
      endcase
      src_gaps = (phase != 3) && ($urandom_range(0, 3) != 0);
      sink_gaps = (phase != 3) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 170) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(dpt_pkg::in_item_t'(4'($urandom_range(0, 15))));
          sent++;
        end else begin
          // steady button level, at times long enough to cross the thresholds
          len = $urandom_range(1, regs.integrator_limit + 8);
          item.button_pressed = 1'($urandom_range(0, 1));
          item.enable_level = ($urandom_range(0, 9) != 0);
          for (int k = 0; k < len; k++) begin
            item.message_seen = ($urandom_range(0, 29) == 0);
            item.ms_tick = 1'($urandom_range(0, 1));
            send_item(item);
          end
          sent += len;
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed_passes();
    test_limit_shrink();
    test_timer_saturation();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
src/dpt_pkg.sv
src/dpt_step.sv
src/debounced_pause_toggle_indicator_core.sv
bench/debounced_pause_toggle_indicator_core_tb.sv
